FILE: rtl/core/cr_tess_pkg.sv
// Shared types, constants and the blend weight function of the spline tessellator.
// Used by the top level, front, queue and back of the block; depends on nothing.

package cr_tess_pkg;

	localparam int SamplesDefault = 10;
	localparam int CoordW = 16;
	localparam int QueueDepth = 4;
	localparam int CountSat = 4;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t [3:0] px;
		coord_t [3:0] py;
		logic raw;
		logic last;
	} job_t;

	function automatic int cr_weight(input int j, input int s, input int k);
		int j2;
		int j3;
		j2 = j * j;
		j3 = j2 * j;
		case (k)
			0: return -j3 + 2 * j2 * s - j * s * s;
			1: return 3 * j3 - 5 * j2 * s + 2 * s * s * s;
			2: return -3 * j3 + 4 * j2 * s + j * s * s;
			default: return j3 - j2 * s;
		endcase
	endfunction

endpackage

FILE: rtl/core/catmull_rom_spline_tessellator_unit.sv
// Top level of the Catmull-Rom spline tessellator: front, job queue and back.
// Depends on cr_tess_pkg, cr_tess_front, cr_tess_fifo and cr_tess_back.
//
// Control points enter on the s_ channel, one per transfer, with s_tlast marking the
// last point of a list. Samples leave on the m_ channel; m_tuser marks an unsmoothed
// point of a list shorter than four, and m_tlast marks the final result of a point.
// The front takes a point and then, while the queue has room, hands one job per cycle to
// a queue of four: a segment job for every segment that the point completes, or one job
// per point of the list when a short list closes. s_tready is low while these jobs go out.
// The back steps through SAMPLES_PER_SEGMENT samples of a segment job and one sample of
// a raw job, one result per cycle while the receiver takes them, so a point yields no
// results, one to three for a short list, or one to three times SAMPLES_PER_SEGMENT; the
// single sample counter of the back sets this rate.
// The first result of a point passes through the front, the queue, the job register
// and six pipeline stages of the blend and divide.
// When the receiver stalls, the whole back pipeline holds; the queue then fills and the
// front holds s_tready low while it has jobs to hand on. Reset empties the queue and
// pipeline and clears the point window and count, so the next point starts a new list.

module catmull_rom_spline_tessellator_unit #(
	parameter int SAMPLES_PER_SEGMENT = cr_tess_pkg::SamplesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // point_x [15:0], point_y [31:16]
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // sample_x [15:0], sample_y [31:16]
	output logic        m_tuser,   // raw_point
	output logic        m_tlast    // last_sample
);
	import cr_tess_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic empty;
	job_t push_data;
	job_t pop_data;
	coord_t sample_x;
	coord_t sample_y;

	cr_tess_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.point_x    (coord_t'(s_tdata[15:0])),
		.point_y    (coord_t'(s_tdata[31:16])),
		.last_point (s_tlast),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	cr_tess_fifo #(
		.DEPTH (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	cr_tess_back #(
		.SAMPLES (SAMPLES_PER_SEGMENT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (empty),
		.job_data    (pop_data),
		.job_pop     (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.sample_x    (sample_x),
		.sample_y    (sample_y),
		.raw_point   (m_tuser),
		.last_sample (m_tlast)
	);

	assign m_tdata = {sample_y, sample_x};

endmodule

FILE: rtl/core/cr_tess_fifo.sv
// Short job queue between the front and the back of the tessellator.
// Depends on cr_tess_pkg for the job type.

module cr_tess_fifo #(
	parameter int DEPTH = cr_tess_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cr_tess_pkg::job_t    push_data,
	output logic                 full,
	input  logic                 pop,
	output cr_tess_pkg::job_t    pop_data,
	output logic                 empty
);
	import cr_tess_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cr_tess_front.sv
// Front of the tessellator: takes control points, keeps the point window and count,
// and turns each point into segment or raw-point jobs. Depends on cr_tess_pkg.

module cr_tess_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cr_tess_pkg::coord_t  point_x,
	input  cr_tess_pkg::coord_t  point_y,
	input  logic                 last_point,
	output logic                 push,
	output cr_tess_pkg::job_t    push_data,
	input  logic                 full
);
	import cr_tess_pkg::*;

	coord_t win_x_q [3];
	coord_t win_y_q [3];
	coord_t cap_x_q [4];
	coord_t cap_y_q [4];
	logic [2:0] cnt_q;
	logic busy_q;
	logic seg_q;
	logic [1:0] k_q;
	logic [1:0] end_q;
	logic [1:0] idx [4];
	logic take;
	logic seg_mode;

	assign in_ready = !busy_q;
	assign take = in_valid && !busy_q;
	assign seg_mode = (cnt_q >= 3'd3);
	assign push = busy_q;

	always_comb begin
		if (seg_q) begin
			case (k_q)
				2'd0: begin
					idx[0] = 2'd0; idx[1] = 2'd0; idx[2] = 2'd1; idx[3] = 2'd2;
				end
				2'd1: begin
					idx[0] = 2'd0; idx[1] = 2'd1; idx[2] = 2'd2; idx[3] = 2'd3;
				end
				default: begin
					idx[0] = 2'd1; idx[1] = 2'd2; idx[2] = 2'd3; idx[3] = 2'd3;
				end
			endcase
		end else begin
			for (int i = 0; i < 4; i++) begin
				idx[i] = k_q;
			end
		end
		for (int i = 0; i < 4; i++) begin
			push_data.px[i] = cap_x_q[idx[i]];
			push_data.py[i] = cap_y_q[idx[i]];
		end
		push_data.raw = !seg_q;
		push_data.last = (k_q == end_q);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 3; i++) begin
				cap_x_q[i] <= win_x_q[i];
				cap_y_q[i] <= win_y_q[i];
			end
			cap_x_q[3] <= point_x;
			cap_y_q[3] <= point_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_x_q[i] <= '0;
				win_y_q[i] <= '0;
			end
			cnt_q <= '0;
			busy_q <= 1'b0;
			seg_q <= 1'b0;
			k_q <= '0;
			end_q <= '0;
		end else if (take) begin
			win_x_q[0] <= win_x_q[1];
			win_x_q[1] <= win_x_q[2];
			win_x_q[2] <= point_x;
			win_y_q[0] <= win_y_q[1];
			win_y_q[1] <= win_y_q[2];
			win_y_q[2] <= point_y;
			if (last_point) begin
				cnt_q <= '0;
			end else if (cnt_q >= 3'(CountSat)) begin
				cnt_q <= 3'(CountSat);
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			busy_q <= seg_mode || last_point;
			seg_q <= seg_mode;
			if (seg_mode) begin
				k_q <= (cnt_q == 3'd3) ? 2'd0 : 2'd1;
				end_q <= last_point ? 2'd2 : 2'd1;
			end else begin
				k_q <= 2'(3'd3 - cnt_q);
				end_q <= 2'd3;
			end
		end else if (busy_q && !full) begin
			if (k_q == end_q) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cr_tess_back.sv
// Back of the tessellator: steps through the samples of each job and blends them in a
// six-stage pipeline with rounding, saturation and a constant divide. Depends on cr_tess_pkg.

module cr_tess_back #(
	parameter int SAMPLES = cr_tess_pkg::SamplesDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_empty,
	input  cr_tess_pkg::job_t    job_data,
	output logic                 job_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cr_tess_pkg::coord_t  sample_x,
	output cr_tess_pkg::coord_t  sample_y,
	output logic                 raw_point,
	output logic                 last_sample
);
	import cr_tess_pkg::*;

	localparam int DEN = 2 * SAMPLES * SAMPLES * SAMPLES;
	localparam int HALF = SAMPLES * SAMPLES * SAMPLES;
	localparam int DW = $clog2(DEN + 1);
	localparam int WW = DW + 1;
	localparam int PW = CoordW + WW;
	localparam int NW = PW + 2;
	localparam int UW = CoordW + DW;
	localparam int JW = $clog2(SAMPLES);
	localparam longint unsigned RECIP = (64'd1 << UW) / DEN;
	localparam logic signed [NW-1:0] HALF_N = NW'(HALF);
	localparam logic signed [NW-1:0] LIM_N = NW'(longint'(32768) * DEN);
	localparam logic [UW-1:0] RECIP_U = UW'(RECIP);
	localparam logic [UW-1:0] DEN_U = UW'(DEN);

	job_t cur_q;
	logic cur_v_q;
	logic [JW-1:0] j_q;
	logic en;
	logic fin;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic raw_s1, raw_s2, raw_s3, raw_s4, raw_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic signed [WW-1:0] w_s1 [4];
	coord_t p_s1 [2][4];
	logic signed [PW-1:0] prod_s2 [2][4];
	logic [UW-1:0] u_s3 [2];
	logic [UW-1:0] u_s4 [2];
	logic [UW-1:0] u_s5 [2];
	logic [1:0] sat_s3 [2];
	logic [1:0] sat_s4 [2];
	logic [1:0] sat_s5 [2];
	logic [CoordW-1:0] qe_s4 [2];
	logic [CoordW-1:0] qe_s5 [2];
	logic [UW-1:0] qd_s5 [2];
	logic signed [NW-1:0] num [2];
	logic [2*UW-1:0] rmul [2];
	logic [UW-1:0] rem [2];
	logic [CoordW-1:0] qf [2];
	coord_t res [2];

	assign en = !out_valid || out_ready;
	assign fin = cur_v_q && (cur_q.raw || (j_q == JW'(SAMPLES - 1)));
	assign job_pop = !job_empty && (!cur_v_q || (en && fin));

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			num[l] = NW'(prod_s2[l][0]) + NW'(prod_s2[l][1]) + NW'(prod_s2[l][2])
				+ NW'(prod_s2[l][3]) + HALF_N;
			rmul[l] = (2 * UW)'(u_s3[l]) * (2 * UW)'(RECIP_U);
			rem[l] = u_s5[l] - qd_s5[l];
			qf[l] = (rem[l] >= DEN_U) ? qe_s5[l] + 1'b1 : qe_s5[l];
			case (sat_s5[l])
				2'b10: res[l] = coord_t'(16'h7FFF);
				2'b01: res[l] = coord_t'(16'h8000);
				default: res[l] = coord_t'(qf[l] ^ 16'h8000);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job_data;
		end
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				w_s1[k] <= WW'(cr_weight(int'(j_q), SAMPLES, k));
				p_s1[0][k] <= cur_q.px[k];
				p_s1[1][k] <= cur_q.py[k];
			end
			raw_s1 <= cur_q.raw;
			last_s1 <= cur_q.last && fin;
			for (int l = 0; l < 2; l++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s2[l][k] <= PW'(p_s1[l][k]) * PW'(w_s1[k]);
				end
				sat_s3[l] <= {num[l] >= LIM_N, num[l] < -LIM_N};
				u_s3[l] <= UW'(num[l] + LIM_N);
				qe_s4[l] <= CoordW'(rmul[l][2*UW-1:UW]);
				u_s4[l] <= u_s3[l];
				sat_s4[l] <= sat_s3[l];
				qd_s5[l] <= UW'(qe_s4[l]) * DEN_U;
				qe_s5[l] <= qe_s4[l];
				u_s5[l] <= u_s4[l];
				sat_s5[l] <= sat_s4[l];
			end
			raw_s2 <= raw_s1;
			last_s2 <= last_s1;
			raw_s3 <= raw_s2;
			last_s3 <= last_s2;
			raw_s4 <= raw_s3;
			last_s4 <= last_s3;
			raw_s5 <= raw_s4;
			last_s5 <= last_s4;
			sample_x <= res[0];
			sample_y <= res[1];
			raw_point <= raw_s5;
			last_sample <= last_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			j_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_v_q <= 1'b1;
				j_q <= '0;
			end else if (en && fin) begin
				cur_v_q <= 1'b0;
			end else if (en && cur_v_q) begin
				j_q <= j_q + 1'b1;
			end
			if (en) begin
				valid_s1 <= cur_v_q;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
				valid_s5 <= valid_s4;
				out_valid <= valid_s5;
			end
		end
	end

endmodule

FILE: rtl/core/cr_tess_checker.sv
// Port-level checks for the spline tessellator, bound to its top level.
// Depends only on the ports of catmull_rom_spline_tessellator_unit.

module cr_tess_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> (!m_tvalid && s_tready))
		else $error("Reset does not leave the block idle.");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("Input ready dropped without an input transfer.");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result withdrawn before its transfer.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("Stalled result changed.");

endmodule

bind catmull_rom_spline_tessellator_unit cr_tess_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
